@@ hw/rtl/group_bandwidth_quota_throttle_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the group bandwidth quota throttle
// ----------------------------------------------------------------------------
`ifndef GROUP_BANDWIDTH_QUOTA_THROTTLE_MACROS_SVH
`define GROUP_BANDWIDTH_QUOTA_THROTTLE_MACROS_SVH

// same-cycle implication
`define GBQT_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define GBQT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hw/rtl/gbqt_pkg.sv @@
// ----------------------------------------------------------------------------
// gbqt_pkg
// types and constants shared by the group bandwidth quota throttle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbqt_pkg;

   localparam int TIME_W     = 48;
   localparam int RUNTIME_W  = 48;
   localparam int QUOTA_W    = 40;
   localparam int PERIOD_W   = 32;
   localparam int EXEC_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int IDX_W      = 3;
   localparam int MASK_W     = 8;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 152;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_ACCOUNT  = 2'd1,
      CMD_CHECK    = 2'd2,
      CMD_SETTINGS = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_QUOTA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFLINE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 3'd4;

   typedef struct packed {
      logic [QUOTA_W-1:0]  quota;
      logic [PERIOD_W-1:0] period;
      logic                offline;
      logic                fair;
      logic [MASK_W-1:0]   active;
   } cfg_type;

   // group controller to unit cells
   typedef struct packed {
      logic              enable;
      logic              release_all;
      logic              throttle;
      logic [TIME_W-1:0] now;
   } unit_ctl_type;

   // unit cell status
   typedef struct packed {
      logic                throttled;
      logic                throttled_next;
      logic [COUNT_W-1:0]  count_next;
      logic [TIME_W-1:0]   total_next;
   } unit_stat_type;

   // group controller status after the step
   typedef struct packed {
      logic [RUNTIME_W-1:0] runtime;
      logic                 timer_on;
   } ctrl_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/group_bandwidth_quota_throttle.sv @@
// response path: the request passes the input register, then the result register
// throughput: one transaction per cycle unless stalled; the step is one pass between registers
// a stalled response holds the result register; the input register then fills and backpressures
// reset: synchronous, clears runtime, clock, timer, all unit flags, counts and totals
// reset: configuration returns to quota 0, period 0, online, fair class, all units active
// ----------------------------------------------------------------------------
// group_bandwidth_quota_throttle
// bandwidth quota throttle for one group over a set of compute units
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_bandwidth_quota_throttle_macros.svh"

module group_bandwidth_quota_throttle
   import gbqt_pkg::*;
#(
   parameter int NUM_UNITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // exec_ticks, xcu_index, runnable_mask
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // command
   input  wire logic [CMD_W-1:0]       req_tuser,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // throttled_mask, dequeue_request, enqueue_mask, runtime_used, timer_active,
   // unit_throttle_count, unit_throttled_time
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int MASK_UNITS = (NUM_UNITS < MASK_W) ? NUM_UNITS : MASK_W;
   localparam int PAD_W      = RSP_DATA_W - (2*MASK_W + 1 + RUNTIME_W + 1 + COUNT_W + TIME_W);

   cfg_type              cfg_ff;
   logic                 in_valid_ff, in_valid_in;
   cmd_type              cmd_ff;
   logic [EXEC_W-1:0]    exec_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [MASK_W-1:0]    runnable_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 proc_w;
   logic                 req_accept_w;

   unit_ctl_type         unit_ctl;
   ctrl_stat_type        ctrl_stat;
   unit_stat_type        unit_stat [NUM_UNITS];
   logic [NUM_UNITS-1:0] sel_w;
   logic [NUM_UNITS-1:0] act_w;
   logic [NUM_UNITS-1:0] flag_w;

   logic [MASK_W-1:0]    tmask_w;
   logic [MASK_W-1:0]    flag_mask_w;
   logic [MASK_W-1:0]    enq_w;
   logic                 deq_w;
   logic [COUNT_W-1:0]   count_w;
   logic [TIME_W-1:0]    total_w;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quota   <= '0;
         cfg_ff.period  <= '0;
         cfg_ff.offline <= 1'b0;
         cfg_ff.fair    <= 1'b1;
         cfg_ff.active  <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUOTA:   cfg_ff.quota   <= csr_wdata[QUOTA_W-1:0];
            CSR_PERIOD:  cfg_ff.period  <= csr_wdata[PERIOD_W-1:0];
            CSR_OFFLINE: cfg_ff.offline <= csr_wdata[0];
            CSR_FAIR:    cfg_ff.fair    <= csr_wdata[0];
            CSR_ACTIVE:  cfg_ff.active  <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake and pipeline control
   assign proc_w       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || proc_w;
   assign req_accept_w = req_tvalid && req_tready;
   assign in_valid_in  = req_accept_w ? 1'b1 : (proc_w ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = proc_w ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept_w) begin
         cmd_ff      <= cmd_type'(req_tuser);
         exec_ff     <= req_tdata[EXEC_W-1:0];
         idx_ff      <= req_tdata[EXEC_W +: IDX_W];
         runnable_ff <= req_tdata[EXEC_W+IDX_W +: MASK_W];
      end
      if (proc_w) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, total_w, count_w, ctrl_stat.timer_on,
                         ctrl_stat.runtime, enq_w, deq_w, tmask_w};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // group controller
   gbqt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .enable     (proc_w),
      .cmd        (cmd_ff),
      .exec_ticks (exec_ff),
      .idx_valid  (|sel_w),
      .cfg        (cfg_ff),
      .ctl        (unit_ctl),
      .stat       (ctrl_stat)
   );

   // unit cells
   for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
      assign sel_w[i] = ({{(32-IDX_W){1'b0}}, idx_ff} == 32'(i));
      if (i < MASK_W) begin : g_act
         assign act_w[i] = cfg_ff.active[i];
      end else begin : g_noact
         assign act_w[i] = 1'b0;
      end
      assign flag_w[i] = unit_stat[i].throttled;

      gbqt_unit u_unit (
         .clock  (clock),
         .reset  (reset),
         .ctl    (unit_ctl),
         .select (sel_w[i]),
         .active (act_w[i]),
         .stat   (unit_stat[i])
      );
   end

   // result assembly
   always_comb begin
      tmask_w     = '0;
      flag_mask_w = '0;
      enq_w       = '0;
      count_w     = '0;
      total_w     = '0;
      for (int k = 0; k < MASK_UNITS; k++) begin
         tmask_w[k]     = unit_stat[k].throttled_next;
         flag_mask_w[k] = unit_stat[k].throttled;
         enq_w[k]       = unit_ctl.release_all && act_w[k] && unit_stat[k].throttled
                          && runnable_ff[k];
      end
      for (int k = 0; k < NUM_UNITS; k++) begin
         if (sel_w[k]) begin
            count_w = unit_stat[k].count_next;
            total_w = unit_stat[k].total_next;
         end
      end
      deq_w = unit_ctl.throttle && |(sel_w & ~flag_w);
   end

   `GBQT_ASSERT_NEXT(a_step_gives_result, clock, reset, proc_w, rsp_tvalid,
      "processed transaction produced no response")
   `GBQT_ASSERT_IMPLIES(a_enqueue_only_throttled, clock, reset, proc_w,
      (enq_w & ~flag_mask_w) == '0, "enqueue of a unit that was not throttled")
   `GBQT_ASSERT_IMPLIES(a_dequeue_sets_flag, clock, reset, proc_w && deq_w,
      (tmask_w & ~flag_mask_w) != '0 || NUM_UNITS > MASK_W,
      "dequeue without a newly throttled unit")

endmodule

`default_nettype wire

@@ hw/rtl/gbqt_unit.sv @@
// ----------------------------------------------------------------------------
// gbqt_unit
// per compute unit throttle flag, start stamp, throttle count and total time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbqt_unit
   import gbqt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire unit_ctl_type  ctl,
   input  wire logic          select,
   input  wire logic          active,
   output unit_stat_type      stat
);

   logic                flag_ff, flag_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]   total_ff, total_in;
   logic                do_throttle;
   logic                do_release;
   logic [TIME_W-1:0]   delta;
   logic [TIME_W:0]     total_sum;

   always_comb begin
      do_throttle = ctl.enable && ctl.throttle && select && !flag_ff;
      do_release  = ctl.enable && ctl.release_all && active && flag_ff;
      delta       = ctl.now - start_ff;
      total_sum   = {1'b0, total_ff} + {1'b0, delta};

      flag_in  = flag_ff;
      start_in = start_ff;
      count_in = count_ff;
      total_in = total_ff;
      if (do_throttle) begin
         flag_in  = 1'b1;
         start_in = ctl.now;
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end else if (do_release) begin
         flag_in  = 1'b0;
         total_in = total_sum[TIME_W] ? '1 : total_sum[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         flag_ff  <= flag_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   assign stat.throttled      = flag_ff;
   assign stat.throttled_next = flag_in;
   assign stat.count_next     = count_in;
   assign stat.total_next     = total_in;

endmodule

`default_nettype wire

@@ hw/rtl/gbqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbqt_ctrl
// group runtime, tick clock and period timer; decides throttle and release
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_bandwidth_quota_throttle_macros.svh"

module gbqt_ctrl
   import gbqt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire cmd_type            cmd,
   input  wire logic [EXEC_W-1:0]  exec_ticks,
   input  wire logic               idx_valid,
   input  wire cfg_type            cfg,
   output unit_ctl_type            ctl,
   output ctrl_stat_type           stat
);

   logic [RUNTIME_W-1:0] runtime_ff, runtime_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 timer_on_ff, timer_on_in;
   logic [PERIOD_W-1:0]  elapsed_ff, elapsed_in;
   logic [PERIOD_W-1:0]  elapsed_inc;
   logic [RUNTIME_W-1:0] quota_ext;
   logic [RUNTIME_W-1:0] refill_rt;
   logic [RUNTIME_W:0]   account_sum;
   logic                 release_all;
   logic                 throttle;

   always_comb begin
      quota_ext   = {{(RUNTIME_W-QUOTA_W){1'b0}}, cfg.quota};
      elapsed_inc = elapsed_ff + 1'b1;
      refill_rt   = (runtime_ff > quota_ext) ? (runtime_ff - quota_ext) : '0;
      account_sum = {1'b0, runtime_ff} + {{(RUNTIME_W+1-EXEC_W){1'b0}}, exec_ticks};

      runtime_in  = runtime_ff;
      time_in     = time_ff;
      timer_on_in = timer_on_ff;
      elapsed_in  = elapsed_ff;
      release_all = 1'b0;
      throttle    = 1'b0;

      case (cmd)
         CMD_TICK: begin
            time_in = time_ff + 1'b1;
            if (timer_on_ff) begin
               if (elapsed_inc >= cfg.period) begin
                  runtime_in  = refill_rt;
                  elapsed_in  = '0;
                  release_all = !cfg.offline && (refill_rt < quota_ext);
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         CMD_ACCOUNT: begin
            runtime_in = account_sum[RUNTIME_W] ? '1 : account_sum[RUNTIME_W-1:0];
         end
         CMD_CHECK: begin
            throttle = (cfg.quota != '0) && (runtime_ff >= quota_ext) && !cfg.offline
                       && idx_valid;
         end
         CMD_SETTINGS: begin
            timer_on_in = 1'b0;
            elapsed_in  = '0;
            if (!cfg.offline && cfg.fair) begin
               if ((cfg.quota != '0) && (cfg.period != '0)) begin
                  timer_on_in = 1'b1;
               end else begin
                  release_all = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runtime_ff  <= '0;
         time_ff     <= '0;
         timer_on_ff <= 1'b0;
         elapsed_ff  <= '0;
      end else if (enable) begin
         runtime_ff  <= runtime_in;
         time_ff     <= time_in;
         timer_on_ff <= timer_on_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   assign ctl.enable      = enable;
   assign ctl.release_all = release_all;
   assign ctl.throttle    = throttle;
   assign ctl.now         = time_in;
   assign stat.runtime    = runtime_in;
   assign stat.timer_on   = timer_on_in;

   `GBQT_ASSERT_IMPLIES(a_timer_idle_elapsed, clock, reset, !timer_on_ff,
      elapsed_ff == '0, "period count nonzero while timer stopped")
   `GBQT_ASSERT_IMPLIES(a_release_throttle_excl, clock, reset, release_all,
      !throttle, "release and throttle in the same step")
   `GBQT_ASSERT_NEXT(a_account_monotonic, clock, reset, enable && (cmd == CMD_ACCOUNT),
      runtime_ff >= $past(runtime_ff), "runtime dropped on account")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives command transactions into the group bandwidth quota throttle, keeps
// a step-accurate predictor of runtime, timer and per-unit throttle state, and
// compares every response in full; random stalls on both streams, a
// long response hold-off and a burst of maximum accounts are included
// ----------------------------------------------------------------------------

module tb_top;
   import gbqt_pkg::*;

   localparam int UNITS = 8;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_PHASES = 14;
   localparam int ACCOUNT_BURST = 40;
   localparam int REFILL_TICKS = 24;
   localparam int REQ_PAD_W = REQ_DATA_W - EXEC_W - IDX_W - MASK_W;
   localparam int RSP_PAD_W = RSP_DATA_W - (2 * MASK_W + 2 + RUNTIME_W + COUNT_W + TIME_W);
   localparam logic [QUOTA_W-1:0] QUOTA_MAX = '1;
   localparam logic [QUOTA_W-1:0] BURST_QUOTA = 40'h10_0000_0000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
   localparam logic [EXEC_W-1:0] EXEC_MAX = '1;

   // request tdata, lowest bits first: exec_ticks, xcu_index, runnable_mask
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [MASK_W-1:0]    runnable;
      logic [IDX_W-1:0]     unit;
      logic [EXEC_W-1:0]    exec;
   } req_item_type;

   // response tdata, lowest bits first: throttled_mask, dequeue_request,
   // enqueue_mask, runtime_used, timer_active, unit_throttle_count,
   // unit_throttled_time
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [TIME_W-1:0]    unit_time;
      logic [COUNT_W-1:0]   unit_count;
      logic                 timer;
      logic [RUNTIME_W-1:0] runtime;
      logic [MASK_W-1:0]    enqueue;
      logic                 dequeue;
      logic [MASK_W-1:0]    throttled;
   } rsp_item_type;

   typedef struct packed {
      logic                  is_cfg;
      logic [CSR_IDX_W-1:0]  cfg_index;
      logic [CSR_DATA_W-1:0] cfg_value;
      cmd_type               cmd;
      req_item_type          item;
      logic                  known;
      rsp_item_type          want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   cfg_type shadow_cfg;
   logic [RUNTIME_W-1:0] runtime_acc;
   logic [TIME_W-1:0] tick_now;
   logic timer_running;
   logic [PERIOD_W-1:0] period_count;
   logic [UNITS-1:0] unit_held;
   logic [TIME_W-1:0] held_since [UNITS];
   logic [COUNT_W-1:0] held_count [UNITS];
   logic [TIME_W-1:0] held_total [UNITS];

   rsp_item_type pending_results [$];
   script_row_type directed_rows [$];
   int errors = 0;
   bit hold_req = 1'b0;
   bit flood = 1'b0;
   bit no_gaps = 1'b0;

   group_bandwidth_quota_throttle #(
      .NUM_UNITS(UNITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(10_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [MASK_W-1:0] release_held_units(logic [MASK_W-1:0] runnable);
      logic [MASK_W-1:0] woken;
      logic [TIME_W-1:0] waited;
      logic [TIME_W:0] sum;
      woken = '0;
      if (!shadow_cfg.offline) begin
         for (int u = 0; u < UNITS; u++) begin
            if (shadow_cfg.active[u] && unit_held[u]) begin
               unit_held[u] = 1'b0;
               waited = tick_now - held_since[u];
               sum = held_total[u] + waited;
               held_total[u] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               held_since[u] = '0;
               if (runnable[u]) woken[u] = 1'b1;
            end
         end
      end
      return woken;
   endfunction

   function automatic rsp_item_type predict_quota_step(cmd_type cmd, req_item_type item);
      rsp_item_type r;
      logic [RUNTIME_W:0] total;
      r = '0;
      case (cmd)
         CMD_TICK: begin
            tick_now = tick_now + 1'b1;
            if (timer_running) begin
               period_count = period_count + 1'b1;
               if (period_count >= shadow_cfg.period) begin
                  runtime_acc = (runtime_acc > shadow_cfg.quota) ?
                                runtime_acc - shadow_cfg.quota : '0;
                  period_count = '0;
                  if (runtime_acc < shadow_cfg.quota)
                     r.enqueue = release_held_units(item.runnable);
               end
            end
         end
         CMD_ACCOUNT: begin
            total = runtime_acc + item.exec;
            runtime_acc = total[RUNTIME_W] ? '1 : total[RUNTIME_W-1:0];
         end
         CMD_CHECK: begin
            if (shadow_cfg.quota != '0 && runtime_acc >= shadow_cfg.quota &&
                !shadow_cfg.offline && !unit_held[item.unit]) begin
               unit_held[item.unit] = 1'b1;
               if (held_count[item.unit] != '1)
                  held_count[item.unit] = held_count[item.unit] + 1'b1;
               held_since[item.unit] = tick_now;
               r.dequeue = 1'b1;
            end
         end
         CMD_SETTINGS: begin
            timer_running = 1'b0;
            period_count = '0;
            if (!shadow_cfg.offline && shadow_cfg.fair) begin
               if (shadow_cfg.quota != '0 && shadow_cfg.period != '0)
                  timer_running = 1'b1;
               else
                  r.enqueue = release_held_units(item.runnable);
            end
         end
         default: begin
         end
      endcase
      r.throttled = unit_held;
      r.runtime = runtime_acc;
      r.timer = timer_running;
      r.unit_count = held_count[item.unit];
      r.unit_time = held_total[item.unit];
      return r;
   endfunction

   function automatic req_item_type random_request(logic [EXEC_W-1:0] exec_span);
      req_item_type item;
      int r;
      item = '0;
      r = $urandom_range(0, 9);
      if (r == 0) item.exec = '0;
      else if (r == 1) item.exec = EXEC_MAX;
      else if (r < 5) item.exec = $urandom;
      else item.exec = $urandom_range(0, exec_span);
      item.unit = IDX_W'($urandom_range(0, UNITS - 1));
      item.runnable = MASK_W'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic req_item_type make_request(logic [EXEC_W-1:0] exec,
                                                 logic [IDX_W-1:0] unit,
                                                 logic [MASK_W-1:0] runnable);
      req_item_type item;
      item = '0;
      item.exec = exec;
      item.unit = unit;
      item.runnable = runnable;
      return item;
   endfunction

   function automatic void add_op(cmd_type cmd, logic [EXEC_W-1:0] exec,
                                  logic [IDX_W-1:0] unit, logic [MASK_W-1:0] runnable);
      script_row_type row;
      row = '0;
      row.cmd = cmd;
      row.item = make_request(exec, unit, runnable);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(cmd_type cmd, logic [EXEC_W-1:0] exec,
                                     logic [IDX_W-1:0] unit, logic [MASK_W-1:0] runnable,
                                     logic [MASK_W-1:0] throttled, logic dequeue,
                                     logic [RUNTIME_W-1:0] runtime, logic timer,
                                     logic [COUNT_W-1:0] count);
      script_row_type row;
      row = '0;
      row.cmd = cmd;
      row.item = make_request(exec, unit, runnable);
      row.known = 1'b1;
      row.want.throttled = throttled;
      row.want.dequeue = dequeue;
      row.want.runtime = runtime;
      row.want.timer = timer;
      row.want.unit_count = count;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_cfg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      script_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_index = index;
      row.cfg_value = value;
      directed_rows.push_back(row);
   endfunction

   // called and returns at a falling edge
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_setting(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_QUOTA: shadow_cfg.quota = value[QUOTA_W-1:0];
         CSR_PERIOD: shadow_cfg.period = value[PERIOD_W-1:0];
         CSR_OFFLINE: shadow_cfg.offline = value[0];
         CSR_FAIR: shadow_cfg.fair = value[0];
         CSR_ACTIVE: shadow_cfg.active = value[MASK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [QUOTA_W-1:0] quota, logic [PERIOD_W-1:0] period,
                            logic offline, logic fair, logic [MASK_W-1:0] active);
      write_setting(CSR_QUOTA, quota);
      write_setting(CSR_PERIOD, CSR_DATA_W'(period));
      write_setting(CSR_OFFLINE, CSR_DATA_W'(offline));
      write_setting(CSR_FAIR, CSR_DATA_W'(fair));
      write_setting(CSR_ACTIVE, CSR_DATA_W'(active));
   endtask

   task automatic send_item(cmd_type cmd, req_item_type item, logic known,
                            rsp_item_type typed_result);
      rsp_item_type want;
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item;
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      want = predict_quota_step(cmd, item);
      pending_results.push_back(known ? typed_result : want);
      @(negedge clock);
   endtask

   // response side backpressure
   initial begin : rsp_stall
      int idle_left;
      int busy_left;
      rsp_tready = 1'b0;
      idle_left = 0;
      busy_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            if (idle_left == 0 && busy_left == 0) begin
               idle_left = flood ? 0 : pick_gap();
               busy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) :
                           $urandom_range(1, 8);
            end
            if (idle_left > 0) begin
               rsp_tready <= 1'b0;
               idle_left--;
            end else begin
               rsp_tready <= 1'b1;
               busy_left--;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb: response with nothing pending at %0t: %h", $realtime, seen);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("tb: mismatch at %0t", $realtime);
                  $display("tb:  exp thr=%h deq=%b enq=%h run=%h tmr=%b cnt=%h tot=%h pad=%h",
                           want.throttled, want.dequeue, want.enqueue, want.runtime,
                           want.timer, want.unit_count, want.unit_time, want.pad);
                  $display("tb:  got thr=%h deq=%b enq=%h run=%h tmr=%b cnt=%h tot=%h pad=%h",
                           seen.throttled, seen.dequeue, seen.enqueue, seen.runtime,
                           seen.timer, seen.unit_count, seen.unit_time, seen.pad);
               end
            end
         end
      end
   end

   initial begin : stimulus
      script_row_type row;
      req_item_type item;
      cmd_type cmd;
      logic [QUOTA_W-1:0] quota;
      logic [PERIOD_W-1:0] period;
      logic [MASK_W-1:0] active;
      logic [EXEC_W-1:0] exec_span;
      int r;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_TICK;
      csr_valid = 1'b0;
      csr_index = CSR_QUOTA;
      csr_wdata = '0;

      shadow_cfg = '0;
      shadow_cfg.fair = 1'b1;
      shadow_cfg.active = '1;
      runtime_acc = '0;
      tick_now = '0;
      timer_running = 1'b0;
      period_count = '0;
      unit_held = '0;
      for (int u = 0; u < UNITS; u++) begin
         held_since[u] = '0;
         held_count[u] = '0;
         held_total[u] = '0;
      end

      // after reset: quota zero, nothing can throttle
      add_known(CMD_TICK, '0, 3'd0, 8'h00, 8'h00, 1'b0, 48'h0, 1'b0, 32'd0);
      add_known(CMD_CHECK, '0, 3'd7, 8'hFF, 8'h00, 1'b0, 48'h0, 1'b0, 32'd0);
      add_known(CMD_ACCOUNT, EXEC_MAX, 3'd3, 8'h00, 8'h00, 1'b0, 48'hFFFF_FFFF, 1'b0, 32'd0);
      add_known(CMD_SETTINGS, '0, 3'd0, 8'hFF, 8'h00, 1'b0, 48'hFFFF_FFFF, 1'b0, 32'd0);
      add_cfg(CSR_QUOTA, 40'h80_0000_00);
      add_cfg(CSR_QUOTA, 40'h8000_0000);
      add_cfg(CSR_PERIOD, 40'd2);
      add_known(CMD_SETTINGS, '0, 3'd0, 8'h00, 8'h00, 1'b0, 48'hFFFF_FFFF, 1'b1, 32'd0);
      add_known(CMD_CHECK, '0, 3'd0, 8'h00, 8'h01, 1'b1, 48'hFFFF_FFFF, 1'b1, 32'd1);
      // already throttled, then two more units
      add_op(CMD_CHECK, '0, 3'd0, 8'h00);
      add_op(CMD_CHECK, '0, 3'd5, 8'h00);
      add_op(CMD_CHECK, '0, 3'd6, 8'h00);
      add_cfg(CSR_ACTIVE, 40'hDF);
      // period end releases active units only
      add_op(CMD_TICK, '0, 3'd0, 8'hFF);
      add_op(CMD_TICK, '0, 3'd6, 8'hFF);
      add_op(CMD_ACCOUNT, EXEC_MAX, 3'd1, 8'h00);
      add_cfg(CSR_OFFLINE, 40'd1);
      add_op(CMD_CHECK, '0, 3'd1, 8'h00);
      add_op(CMD_SETTINGS, '0, 3'd1, 8'hFF);
      add_cfg(CSR_OFFLINE, 40'd0);
      add_cfg(CSR_FAIR, 40'd0);
      add_op(CMD_SETTINGS, '0, 3'd2, 8'hFF);
      add_cfg(CSR_FAIR, 40'd1);
      add_cfg(CSR_PERIOD, 40'd0);
      // quota with no period releases on settings change
      add_op(CMD_SETTINGS, '0, 3'd5, 8'hFF);
      add_cfg(CSR_ACTIVE, 40'hFF);
      add_op(CMD_SETTINGS, '0, 3'd5, 8'hAA);
      add_cfg(CSR_PERIOD, 40'd1);
      add_op(CMD_CHECK, '0, 3'd2, 8'h00);
      add_op(CMD_SETTINGS, '0, 3'd0, 8'h00);
      add_op(CMD_TICK, '0, 3'd2, 8'h04);
      // period dropped to zero while the timer runs
      add_cfg(CSR_PERIOD, 40'd0);
      add_op(CMD_ACCOUNT, 32'h1234_5678, 3'd4, 8'h55);
      add_op(CMD_CHECK, '0, 3'd4, 8'h55);
      add_op(CMD_TICK, '0, 3'd4, 8'hFF);
      add_cfg(CSR_QUOTA, 40'd0);
      add_op(CMD_TICK, '0, 3'd4, 8'hFF);
      add_op(CMD_ACCOUNT, '0, 3'd7, 8'h80);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg)
            write_setting(row.cfg_index, row.cfg_value);
         else
            send_item(row.cmd, row.item, row.known, row.want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 9);
         if (r == 0) quota = '0;
         else if (r == 1) quota = QUOTA_MAX;
         else if (r == 2) quota = QUOTA_W'({$urandom, $urandom});
         else quota = QUOTA_W'($urandom_range(1, 2000));
         r = $urandom_range(0, 9);
         if (r == 0) period = '0;
         else if (r == 1) period = PERIOD_MAX;
         else if (r == 2) period = $urandom;
         else period = $urandom_range(1, 12);
         r = $urandom_range(0, 9);
         if (r == 0) active = '0;
         else if (r == 1) active = '1;
         else active = MASK_W'($urandom_range(0, 255));
         if (phase == 0) begin
            quota = QUOTA_W'(1);
            period = PERIOD_MAX;
            active = '0;
         end
         configure(quota, period, $urandom_range(0, 4) == 0, $urandom_range(0, 5) != 0,
                   active);
         if (quota == '0) exec_span = 1000;
         else if (quota > EXEC_MAX) exec_span = EXEC_MAX;
         else exec_span = quota[EXEC_W-1:0];

         no_gaps = ($urandom_range(0, 4) == 0);
         if (phase == 2) begin
            hold_req = 1'b1;
            no_gaps = 1'b1;
         end
         if ($urandom_range(0, 4) != 0)
            send_item(CMD_SETTINGS, random_request(exec_span), 1'b0, '0);
         repeat ($urandom_range(40, 60)) begin
            r = $urandom_range(0, 19);
            if (r < 8) cmd = CMD_TICK;
            else if (r < 13) cmd = CMD_ACCOUNT;
            else if (r < 18) cmd = CMD_CHECK;
            else cmd = CMD_SETTINGS;
            send_item(cmd, random_request(exec_span), 1'b0, '0);
         end
      end

      // burst of maximum accounts, throttle every unit, then refill every tick
      no_gaps = 1'b1;
      configure(BURST_QUOTA, PERIOD_W'(1), 1'b0, 1'b1, '1);
      flood = 1'b1;
      send_item(CMD_SETTINGS, random_request(EXEC_MAX), 1'b0, '0);
      repeat (ACCOUNT_BURST) begin
         item = random_request(EXEC_MAX);
         item.exec = EXEC_MAX;
         send_item(CMD_ACCOUNT, item, 1'b0, '0);
      end
      for (int u = 0; u < UNITS; u++)
         send_item(CMD_CHECK, make_request($urandom, IDX_W'(u), MASK_W'($urandom_range(0, 255))),
                   1'b0, '0);
      repeat (REFILL_TICKS)
         send_item(CMD_TICK, random_request(EXEC_MAX), 1'b0, '0);
      flood = 1'b0;
      no_gaps = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/gbqt_pkg.sv
hw/rtl/gbqt_unit.sv
hw/rtl/gbqt_ctrl.sv
hw/rtl/group_bandwidth_quota_throttle.sv
sim/tb_top.sv
